// ===== rtl/bsts_pkg.sv =====
// Shared types and constants of the bicubic spherical table sampler.
package bsts_pkg;

  localparam int MAX_THETA_DEF = 64;
  localparam int MAX_PHI_DEF   = 64;

  localparam int CNT_REG_W = 7;   // count register width
  localparam int CNT_W     = 11;  // effective count, holds up to 2047
  localparam int POS_W     = 16 + CNT_W;
  localparam int MA_W      = 38;  // shared multiplier operand A
  localparam int MB_W      = 19;  // shared multiplier operand B
  localparam int MP_W      = 57;  // product
  localparam int W_W       = 17;  // Q2.14 weight
  localparam int WS_W      = 36;  // weight sum
  localparam int FS_W      = 52;  // weighted sum
  localparam int QB        = 20;  // quotient bits
  localparam int DV_W      = WS_W + QB;
  localparam int ONE_Q15   = 32768;

  typedef enum logic [0:0] {
    CFG_THETA_COUNT = 1'b0,
    CFG_PHI_COUNT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [5:0]  row_index;
    logic [5:0]  column_index;
    logic [15:0] entry_value;
    logic [15:0] theta_angle;
    logic [15:0] phi_angle;
  } sample_req_t;

  typedef struct packed {
    logic [15:0] attenuation;
    logic        table_too_small;
  } sample_res_t;

endpackage

// ===== rtl/bsts_mul.sv =====
// Shared signed multiplier with registered product.
module bsts_mul import bsts_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [MA_W-1:0] a_i,
  input  logic signed [MB_W-1:0] b_i,
  output logic signed [MP_W-1:0] p_o
);

  logic signed [MP_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MP_W'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/bicubic_spherical_table_sampler_top.sv =====
// Top level of the bicubic spherical table sampler.
//
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 theta_count,
// 1 phi_count) and cfg_data_i. cfg_ready_o is always high; write only while idle.
// Commands: a transaction is taken when start_i is high and busy_o is low.
// A table write (op 0) completes at once, gives no result, and busy_o stays low.
// A sample (op 1) raises busy_o through four phases: grid positions, the eight
// Keys weights (two products each), the 16 taps (two products and one table read
// each) and the restoring divide. All products go through the one shared
// multiplier. No new command is taken while busy_o is high. A sample on a
// table with a count below two returns at once.
// Results: res_valid_o pulses for one cycle with res_o; busy_o falls in the same
// cycle. The receiver cannot stall; a result is shown exactly once.
// Reset: counts clear to zero and the sequencer idles. The table is not
// cleared; entries must be written before they are sampled.
module bicubic_spherical_table_sampler_top import bsts_pkg::*; #(
  parameter int MAX_THETA = MAX_THETA_DEF,
  parameter int MAX_PHI   = MAX_PHI_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CNT_REG_W-1:0] cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  sample_req_t          req_i,
  output logic                 res_valid_o,
  output sample_res_t          res_o
);

  localparam int DEPTH = MAX_PHI * MAX_THETA;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POS  = 5'b00010,
    S_WGT  = 5'b00100,
    S_TAP  = 5'b01000,
    S_DIV  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [CNT_REG_W-1:0] theta_count_q, theta_count_d, phi_count_q, phi_count_d;
  logic [CNT_W-1:0] nt_q, nt_d, np_q, np_d;
  logic [15:0] theta_q, theta_d, phi_q, phi_d;
  logic [POS_W-1:0] pt_q, pt_d, pp_q, pp_d;
  logic near_q, near_d;
  logic signed [W_W-1:0] wt_q [4];
  logic signed [W_W-1:0] wt_d [4];
  logic signed [W_W-1:0] wp_q [4];
  logic signed [W_W-1:0] wp_d [4];
  logic signed [FS_W-1:0] fsum_q, fsum_d, fsum_fin;
  logic signed [WS_W-1:0] wsum_q, wsum_d;
  logic [DV_W-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [QB-1:0] quo_q, quo_d, quo_fin;
  logic zero_q, zero_d;
  sample_res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;

  logic accept;
  logic [CNT_W-1:0] nt_eff, np_eff;
  logic [2:0] wj, wj_prev;
  logic [15:0] frac;
  logic [17:0] t_cur;
  logic t_near;
  logic signed [MP_W-1:0] num_r;
  logic signed [W_W-1:0] w_cap;
  logic signed [CNT_W+1:0] ti, pi;
  logic [CNT_W-1:0] col_v, row_v, m_phi;
  logic ge;

  bsts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign nt_eff = (32'(theta_count_q) > MAX_THETA) ? CNT_W'(MAX_THETA)
                                                   : CNT_W'(theta_count_q);
  assign np_eff = (32'(phi_count_q) > MAX_PHI) ? CNT_W'(MAX_PHI) : CNT_W'(phi_count_q);

  assign wr_addr = AW'(32'(req_i.row_index) * MAX_THETA + 32'(req_i.column_index));
  assign wr_en   = accept && (req_i.op == OP_WRITE) &&
                   (32'(req_i.row_index) < MAX_PHI) && (32'(req_i.column_index) < MAX_THETA);

  // Weight sequencing: two products per weight, theta weights first.
  assign wj      = cnt_q[3:1];
  assign wj_prev = wj - 3'd1;
  assign frac    = wj[2] ? pp_q[15:0] : pt_q[15:0];

  always_comb begin
    case (wj[1:0])
      2'd0:    t_cur = 18'd65536 + {2'b00, frac};
      2'd1:    t_cur = {2'b00, frac};
      2'd2:    t_cur = 18'd65536 - {2'b00, frac};
      default: t_cur = 18'd131072 - {2'b00, frac};
    endcase
  end

  assign t_near = (t_cur <= 18'd65536);
  assign num_r  = mul_p + (near_q ? (MP_W'(1) <<< 49) : (MP_W'(1) <<< 50))
                        + (MP_W'(1) <<< 34);
  assign w_cap  = num_r[W_W+34:35];

  // Tap addressing: theta clamps, phi wraps modulo phi_count-1.
  assign ti = $signed({2'b00, pt_q[POS_W-1:16]}) + $signed({{CNT_W{1'b0}}, cnt_q[2:1]})
              - (CNT_W+2)'(1);
  assign pi = $signed({2'b00, pp_q[POS_W-1:16]}) + $signed({{CNT_W{1'b0}}, cnt_q[4:3]})
              - (CNT_W+2)'(1);
  assign m_phi = np_q - CNT_W'(1);

  always_comb begin
    if (ti < 0) begin
      col_v = '0;
    end else if (ti > $signed({2'b00, nt_q - CNT_W'(1)})) begin
      col_v = nt_q - CNT_W'(1);
    end else begin
      col_v = ti[CNT_W-1:0];
    end
    if (pi < 0) begin
      row_v = m_phi - CNT_W'(1);
    end else if (pi >= $signed({1'b0, m_phi, 1'b0})) begin
      row_v = pi[CNT_W-1:0] - {m_phi[CNT_W-2:0], 1'b0};
    end else if (pi >= $signed({2'b00, m_phi})) begin
      row_v = pi[CNT_W-1:0] - m_phi;
    end else begin
      row_v = pi[CNT_W-1:0];
    end
  end

  assign rd_addr = AW'(32'(row_v) * MAX_THETA + 32'(col_v));

  assign fsum_fin = fsum_q + $signed(mul_p[FS_W-1:0]);
  assign ge       = (rem_q >= dv_q);
  assign quo_fin  = {quo_q[QB-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= req_i.entry_value;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    theta_count_d = theta_count_q;
    phi_count_d   = phi_count_q;
    nt_d          = nt_q;
    np_d          = np_q;
    theta_d       = theta_q;
    phi_d         = phi_q;
    pt_d          = pt_q;
    pp_d          = pp_q;
    near_d        = near_q;
    wt_d          = wt_q;
    wp_d          = wp_q;
    fsum_d        = fsum_q;
    wsum_d        = wsum_q;
    rem_d         = rem_q;
    dv_d          = dv_q;
    quo_d         = quo_q;
    zero_d        = zero_q;
    res_d         = res_q;
    res_valid_d   = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_THETA_COUNT: theta_count_d = cfg_data_i;
        CFG_PHI_COUNT:   phi_count_d   = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept && (req_i.op == OP_SAMPLE)) begin
          nt_d    = nt_eff;
          np_d    = np_eff;
          theta_d = req_i.theta_angle;
          phi_d   = req_i.phi_angle;
          if (nt_eff < CNT_W'(2) || np_eff < CNT_W'(2)) begin
            res_d.attenuation     = '0;
            res_d.table_too_small = 1'b1;
            res_valid_d           = 1'b1;
          end else begin
            state_d = S_POS;
            cnt_d   = '0;
          end
        end
      end
      S_POS: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd0) begin
          mul_a = $signed({{(MA_W-16){1'b0}}, theta_q});
          mul_b = $signed({{(MB_W-CNT_W){1'b0}}, nt_q - CNT_W'(1)});
        end else if (cnt_q == 6'd1) begin
          mul_a = $signed({{(MA_W-16){1'b0}}, phi_q});
          mul_b = $signed({{(MB_W-CNT_W){1'b0}}, np_q - CNT_W'(1)});
          pt_d  = mul_p[POS_W-1:0];
        end else begin
          pp_d    = mul_p[POS_W-1:0];
          state_d = S_WGT;
          cnt_d   = '0;
        end
      end
      S_WGT: begin
        cnt_d = cnt_q + 6'd1;
        if (!cnt_q[0]) begin
          if (cnt_q != 6'd0) begin
            if (wj_prev[2]) begin
              wp_d = '{wp_q[1], wp_q[2], wp_q[3], w_cap};
            end else begin
              wt_d = '{wt_q[1], wt_q[2], wt_q[3], w_cap};
            end
          end
          if (cnt_q == 6'd16) begin
            state_d = S_TAP;
            cnt_d   = '0;
            fsum_d  = '0;
            wsum_d  = '0;
          end else begin
            // First Horner step; near and far branches of the kernel.
            near_d = t_near;
            mul_a  = t_near ? $signed(MA_W'(t_cur) * MA_W'(3) - MA_W'(327680))
                            : $signed(MA_W'(327680) - MA_W'(t_cur));
            mul_b  = $signed({1'b0, t_cur});
          end
        end else begin
          mul_a = near_q ? mul_p[MA_W-1:0] : mul_p[MA_W-1:0] - (MA_W'(1) << 35);
          mul_b = $signed({1'b0, t_cur});
        end
      end
      S_TAP: begin
        cnt_d = cnt_q + 6'd1;
        if (!cnt_q[0]) begin
          if (cnt_q != 6'd0) begin
            fsum_d = fsum_fin;
          end
          if (cnt_q == 6'd32) begin
            zero_d  = (wsum_q <= 0) || (fsum_fin <= 0);
            rem_d   = (DV_W'(fsum_fin) << 1) + DV_W'(wsum_q);
            dv_d    = DV_W'(wsum_q) << QB;
            state_d = S_DIV;
            cnt_d   = '0;
          end else begin
            mul_a = MA_W'(wp_q[0]);
            mul_b = MB_W'(wt_q[0]);
            wt_d  = '{wt_q[1], wt_q[2], wt_q[3], wt_q[0]};
            if (cnt_q[2:1] == 2'd3) begin
              wp_d = '{wp_q[1], wp_q[2], wp_q[3], wp_q[0]};
            end
          end
        end else begin
          wsum_d = wsum_q + $signed(mul_p[WS_W-1:0]);
          mul_a  = mul_p[MA_W-1:0];
          mul_b  = $signed({{(MB_W-16){1'b0}}, rd_q});
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (ge) begin
          rem_d = rem_q - dv_q;
        end
        dv_d  = dv_q >> 1;
        quo_d = quo_fin;
        if (cnt_q == 6'(QB - 1)) begin
          state_d               = S_IDLE;
          res_valid_d           = 1'b1;
          res_d.table_too_small = 1'b0;
          if (zero_q) begin
            res_d.attenuation = '0;
          end else if (quo_fin > QB'(ONE_Q15)) begin
            res_d.attenuation = 16'(ONE_Q15);
          end else begin
            res_d.attenuation = quo_fin[15:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      theta_count_q <= '0;
      phi_count_q   <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      theta_count_q <= theta_count_d;
      phi_count_q   <= phi_count_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nt_q    <= nt_d;
    np_q    <= np_d;
    theta_q <= theta_d;
    phi_q   <= phi_d;
    pt_q    <= pt_d;
    pp_q    <= pp_d;
    near_q  <= near_d;
    wt_q    <= wt_d;
    wp_q    <= wp_d;
    fsum_q  <= fsum_d;
    wsum_q  <= wsum_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
    zero_q  <= zero_d;
    res_q   <= res_d;
  end

endmodule

// ===== rtl/bsts_checker.sv =====
// Port-level assertions for the sampler, bound to the top level.
module bsts_checker import bsts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input sample_req_t req_i,
  input logic        res_valid_o,
  input sample_res_t res_o
);

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.op == OP_WRITE) |=> !res_valid_o)
    else $error("table write produced a result");

  a_sample_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.op == OP_SAMPLE) |=> busy_o || res_valid_o)
    else $error("sample transaction dropped");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o)
    else $error("sample finished without result");

  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.table_too_small |-> res_o.attenuation == 16'd0)
    else $error("small table result not zero");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.attenuation <= 16'(ONE_Q15))
    else $error("attenuation above one");

endmodule

bind bicubic_spherical_table_sampler_top bsts_checker u_bsts_checker (.*);

// ===== verif/bicubic_spherical_table_sampler_top_tb.sv =====
// Testbench for the bicubic spherical table sampler: table fill, sampling and count settings.
`timescale 1ns / 100ps

module bicubic_spherical_table_sampler_top_tb;
  import bsts_pkg::*;

  localparam int TBL_COLS   = 64;
  localparam int TBL_ROWS   = 64;
  localparam int FILL_ROWS  = 3;   // full-width rows: any theta count with phi count up to 4
  localparam int FILL_COLS  = 3;   // full-height columns: any phi count with theta count up to 3
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i = 1'b0;
  logic [CNT_REG_W-1:0] cfg_data_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  sample_req_t          req_i = '0;
  logic                 res_valid_o;
  sample_res_t          res_o;

  bicubic_spherical_table_sampler_top dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start_i, .busy_o, .req_i, .res_valid_o, .res_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sample_req_t pend_q[$];
  sample_res_t atten_q[$];
  logic [15:0] table_mirror [TBL_ROWS*TBL_COLS];
  int          theta_reg = 0;
  int          phi_reg = 0;
  int          errors = 0;
  int          n_samples = 0;
  int          n_writes = 0;
  int          n_small = 0;
  int          n_cfg = 0;
  int          gap = 0;
  longint      cycles = 0;

  function automatic void enqueue(sample_req_t rq);
    pend_q = {pend_q, rq};
  endfunction

  // Keys kernel, a = -0.5, distance in Q16, weight in Q2.14 rounded half up.
  function automatic longint keys_w(longint d);
    longint t, t2, t3, num;
    t = (d < 0) ? -d : d;
    if (t >= (longint'(2) << 16)) return 0;
    t2 = t * t;
    t3 = t2 * t;
    if (t <= (longint'(1) << 16))
      num = 3 * t3 - 5 * t2 * 65536 + (longint'(2) << 48);
    else
      num = -t3 + 5 * t2 * 65536 - 8 * t * (longint'(1) << 32) + (longint'(4) << 48);
    num = num + (longint'(1) << 51) + (longint'(1) << 34);
    return (num >>> 35) - (longint'(1) << 16);
  endfunction

  // Updates the table mirror for writes; returns 1 with the attenuation for samples.
  function automatic bit predict_atten(sample_req_t rq, output sample_res_t r);
    longint nt, np, pt, pp, tmin, tmax, pmin, pmax, m, ti, pj, wp, w, row, col;
    longint fsum, wsum, q;
    r = '0;
    if (op_e'(rq.op) == OP_WRITE) begin
      table_mirror[rq.row_index * TBL_COLS + rq.column_index] = rq.entry_value;
      return 1'b0;
    end
    nt = (theta_reg > MAX_THETA_DEF) ? MAX_THETA_DEF : theta_reg;
    np = (phi_reg > MAX_PHI_DEF) ? MAX_PHI_DEF : phi_reg;
    if (nt < 2 || np < 2) begin
      r.table_too_small = 1'b1;
      return 1'b1;
    end
    pt = longint'(rq.theta_angle) * (nt - 1);
    pp = longint'(rq.phi_angle) * (np - 1);
    tmax = (pt >>> 16) + 2;
    tmin = (pt & 16'hFFFF) ? (pt >>> 16) - 1 : (pt >>> 16) - 2;
    pmax = (pp >>> 16) + 2;
    pmin = (pp & 16'hFFFF) ? (pp >>> 16) - 1 : (pp >>> 16) - 2;
    m = np - 1;
    fsum = 0;
    wsum = 0;
    for (pj = pmin; pj <= pmax; pj++) begin
      wp = keys_w(pj * 65536 - pp);
      row = ((pj % m) + m) % m; // last phi row repeats the first
      for (ti = tmin; ti <= tmax; ti++) begin
        col = (ti < 0) ? 0 : ((ti > nt - 1) ? nt - 1 : ti);
        w = wp * keys_w(ti * 65536 - pt);
        fsum += w * longint'(table_mirror[row * TBL_COLS + col]);
        wsum += w;
      end
    end
    if (wsum <= 0 || fsum <= 0) q = 0;
    else begin
      q = (2 * fsum + wsum) / (2 * wsum);
      if (q > ONE_Q15) q = ONE_Q15;
    end
    r.attenuation = q[15:0];
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return 0;
    if (sel < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic        go;
    sample_res_t r;
    go = start_i;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (predict_atten(req_i, r)) begin
          atten_q = {atten_q, r};
          n_samples++;
          if (r.table_too_small) n_small++;
        end else n_writes++;
        void'(pend_q.pop_front());
        go = 1'b0;
        gap = pick_gap();
      end
      if (!go) begin
        if (gap > 0) gap--;
        else if (pend_q.size() > 0) begin
          go = 1'b1;
          req_i <= pend_q[0];
        end
      end
    end
    start_i <= go;
  end

  // monitor
  always @(posedge clk_i) begin
    sample_res_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (atten_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h/%b", $time,
                 res_o.attenuation, res_o.table_too_small);
        errors++;
      end else begin
        exp_r = atten_q.pop_front();
        if (res_o.attenuation !== exp_r.attenuation) begin
          $display("%0t: attenuation mismatch expected %h actual %h", $time,
                   exp_r.attenuation, res_o.attenuation);
          errors++;
        end
        if (res_o.table_too_small !== exp_r.table_too_small) begin
          $display("%0t: table_too_small mismatch expected %b actual %b", $time,
                   exp_r.table_too_small, res_o.table_too_small);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CNT_REG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_THETA_COUNT) theta_reg = val & 7'h7F;
    else phi_reg = val & 7'h7F;
    n_cfg++;
  endtask

  // Sender holds off until every queued transaction is sent and every sample has returned.
  task automatic drain();
    while (pend_q.size() > 0 || atten_q.size() > 0 || start_i) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic sample_req_t mk_sample(int th, int ph);
    sample_req_t rq;
    rq.op           = OP_SAMPLE;
    rq.row_index    = 6'($urandom());
    rq.column_index = 6'($urandom());
    rq.entry_value  = 16'($urandom());
    rq.theta_angle  = 16'(th);
    rq.phi_angle    = 16'(ph);
    return rq;
  endfunction

  function automatic sample_req_t mk_write(int row, int col, int val);
    sample_req_t rq;
    rq.op           = OP_WRITE;
    rq.row_index    = 6'(row);
    rq.column_index = 6'(col);
    rq.entry_value  = 16'(val);
    rq.theta_angle  = 16'($urandom());
    rq.phi_angle    = 16'($urandom());
    return rq;
  endfunction

  function automatic int rand_angle();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return 0;
      1: return 65535;
      2: return 32768;
      3: return 16384;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_entry();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 65535);
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? ONE_Q15 : 0;
    return $urandom_range(0, ONE_Q15);
  endfunction

  // each pair keeps the taps inside the filled rows or the filled columns
  int th_set[13] = '{1, 5, 2, 64, 127, 64, 2, 3, 33, 0, 0, 0, 0};
  int ph_set[13] = '{5, 1, 2, 4, 3, 2, 64, 127, 4, 40, 0, 0, 0};

  initial begin
    int v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // counts are zero out of reset: small-table result without touching the table
    enqueue(mk_sample(0, 0));
    enqueue(mk_sample(65535, 65535));

    // fill the first rows across all columns and the first columns down all rows
    for (int r = 0; r < TBL_ROWS; r++)
      for (int c = 0; c < TBL_COLS; c++) begin
        if (r >= FILL_ROWS && c >= FILL_COLS) continue;
        if ((r + c) % 7 == 0) v = ONE_Q15;
        else if ((r * c) % 11 == 3) v = 0;
        else if ((r ^ c) == 63) v = 65535;
        else v = rand_entry();
        enqueue(mk_write(r, c, v));
      end
    drain();

    for (int s = 10; s < 13; s++) begin
      th_set[s] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 64);
      ph_set[s] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 64);
      if (th_set[s] > FILL_COLS && ph_set[s] > FILL_ROWS + 1) begin
        if ($urandom_range(0, 1) != 0) th_set[s] = $urandom_range(2, FILL_COLS);
        else ph_set[s] = $urandom_range(2, FILL_ROWS + 1);
      end
    end

    for (int s = 0; s < 13; s++) begin
      cfg_write(CFG_THETA_COUNT, th_set[s]);
      cfg_write(CFG_PHI_COUNT, ph_set[s]);
      // angle corners on each setting
      enqueue(mk_sample(0, 0));
      enqueue(mk_sample(65535, 65535));
      enqueue(mk_sample(32768, 0));
      enqueue(mk_sample(0, 65535));
      for (int k = 0; k < 14; k++) begin
        if ($urandom_range(0, 3) == 0)
          enqueue(mk_write($urandom_range(0, 63), $urandom_range(0, 63), rand_entry()));
        else
          enqueue(mk_sample(rand_angle(), rand_angle()));
      end
      drain();
    end

    $display("covered %0d samples (%0d on a too-small table) and %0d table writes",
             n_samples, n_small, n_writes);
    $display("over %0d count register writes, including zero, one, 64 and 127",
             n_cfg);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsts_pkg.sv
rtl/bsts_mul.sv
rtl/bicubic_spherical_table_sampler_top.sv
rtl/bsts_checker.sv
verif/bicubic_spherical_table_sampler_top_tb.sv
